### hw/rtl/lcd_pkg.sv
`timescale 1ns / 1ps

package lcd_pkg;

	// Lane is 64 units of 1/16 m wide; the lane index is 2 bits wide.
	localparam int LANE_IDX_W = 2;
	localparam int POS_W      = 17;
	localparam int LAT_W      = 8;
	localparam int SPEED_W    = 12;
	localparam int FCOUNT_W   = 8;

	// Register indexes on the APB port (byte address 4*index).
	localparam logic [1:0] REG_MAX_SPEED   = 2'd0;
	localparam logic [1:0] REG_SPEED_STEP  = 2'd1;
	localparam logic [1:0] REG_LOCK_FRAMES = 2'd2;
	localparam logic [1:0] REG_SAFETY_GAP  = 2'd3;

	localparam logic [11:0] MAX_SPEED_RST   = 12'd2200;
	localparam logic [7:0]  SPEED_STEP_RST  = 8'd10;
	localparam logic [7:0]  LOCK_FRAMES_RST = 8'd100;
	localparam logic [9:0]  SAFETY_GAP_RST  = 10'd400;

	typedef enum logic [1:0] {
		MODE_KEEP  = 2'd0,
		MODE_TRACK = 2'd1,
		MODE_LEFT  = 2'd2,
		MODE_RIGHT = 2'd3
	} mode_t;

	typedef struct packed {
		logic [POS_W-1:0] ego_s;
		logic [POS_W-1:0] horizon_s;
		logic [POS_W-1:0] other_s;
		logic [LAT_W-1:0] other_d;
		logic             other_valid;
		logic             frame_end;
	} item_t;

	typedef struct packed {
		logic [11:0] max_speed;
		logic [7:0]  speed_step;
		logic [7:0]  lock_frames;
		logic [9:0]  safety_gap;
	} cfg_t;

	typedef struct packed {
		logic [LANE_IDX_W-1:0] lane;
		logic [SPEED_W-1:0]    speed;
		logic                  locked;
		logic [FCOUNT_W-1:0]   fcount;
		logic                  ahead;
		logic                  left_busy;
		logic                  right_busy;
	} state_t;

	typedef struct packed {
		logic [LANE_IDX_W-1:0] lane;
		mode_t                 mode;
		logic [SPEED_W-1:0]    ref_speed;
		logic [LAT_W-1:0]      target_d;
		logic                  change_locked;
	} result_t;

endpackage

### hw/rtl/lane_change_decision.sv
`timescale 1ns / 1ps

// Lane change decision. Each input item carries ego position, path end and at
// most one surrounding vehicle (s_tuser = vehicle present); s_tlast marks the
// last item of a frame. Vehicle items set sticky flags (vehicle ahead in own
// lane, left lane busy, right lane busy); the frame-end item decides keep,
// brake, pass left or pass right, updates lane, speed, lock and frame count,
// and produces exactly one result. Other items produce none. Throughput is one
// item per clock: an input register feeds one pass of compare/decide logic
// that writes the state and the output register in the same cycle, so the
// next item sees the updated flags. A frame-end item passes through the input
// register, then the output register, onto m_tvalid. Input only stalls when a
// frame-end item sits in the input register while the output register still
// holds a result not yet taken. Configuration (APB, byte addresses 0x0
// max_speed, 0x4 speed_step, 0x8 lock_frames, 0xC safety_gap) is to be
// written only while the block is idle; the user is bound to this, and the
// block itself does not enforce it.
module lane_change_decision
	import lcd_pkg::*;
#(
	parameter int LANE_COUNT = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // ego_s[16:0], horizon_s[33:17], other_s[50:34],
	                               // other_d[58:51], zero fill
	input  logic        s_tuser,   // other_valid
	input  logic        s_tlast,   // frame_end
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // lane[1:0], mode[3:2], ref_speed[15:4],
	                               // target_d[23:16], change_locked[24], zero fill
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int NL = (LANE_COUNT > 4) ? 4 : ((LANE_COUNT < 1) ? 1 : LANE_COUNT);

	item_t   item_s1;
	logic    valid_s1;
	logic    adv_s1;
	cfg_t    cfg_q;
	state_t  st_q, st_nxt;
	result_t res, res_q;
	logic    out_valid_q;
	logic    cfg_wr;
	logic [1:0] reg_idx;

	// ---------------- configuration ----------------
	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_speed   <= MAX_SPEED_RST;
			cfg_q.speed_step  <= SPEED_STEP_RST;
			cfg_q.lock_frames <= LOCK_FRAMES_RST;
			cfg_q.safety_gap  <= SAFETY_GAP_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_MAX_SPEED:   cfg_q.max_speed   <= pwdata[11:0];
				REG_SPEED_STEP:  cfg_q.speed_step  <= pwdata[7:0];
				REG_LOCK_FRAMES: cfg_q.lock_frames <= pwdata[7:0];
				REG_SAFETY_GAP:  cfg_q.safety_gap  <= pwdata[9:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_MAX_SPEED:   prdata = {20'b0, cfg_q.max_speed};
			REG_SPEED_STEP:  prdata = {24'b0, cfg_q.speed_step};
			REG_LOCK_FRAMES: prdata = {24'b0, cfg_q.lock_frames};
			REG_SAFETY_GAP:  prdata = {22'b0, cfg_q.safety_gap};
			default:         prdata = '0;
		endcase
	end

	// ---------------- input register ----------------
	// A non-frame-end item needs no result slot, so it always moves on.
	assign adv_s1   = valid_s1 && (!item_s1.frame_end || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.ego_s       <= s_tdata[16:0];
			item_s1.horizon_s   <= s_tdata[33:17];
			item_s1.other_s     <= s_tdata[50:34];
			item_s1.other_d     <= s_tdata[58:51];
			item_s1.other_valid <= s_tuser;
			item_s1.frame_end   <= s_tlast;
		end
	end

	// ---------------- decision logic ----------------
	lcd_decide #(
		.LANE_COUNT(LANE_COUNT)
	) u_decide (
		.item   (item_s1),
		.st     (st_q),
		.cfg    (cfg_q),
		.st_nxt (st_nxt),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.lane       <= 2'd1;
			st_q.speed      <= '0;
			st_q.locked     <= 1'b0;
			st_q.fcount     <= '0;
			st_q.ahead      <= 1'b0;
			st_q.left_busy  <= 1'b0;
			st_q.right_busy <= 1'b0;
		end else if (adv_s1) begin
			st_q <= st_nxt;
		end
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && item_s1.frame_end) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && item_s1.frame_end) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'b0, res_q.change_locked, res_q.target_d, res_q.ref_speed,
		res_q.mode, res_q.lane};

	// ---------------- assertions ----------------
	// lane never leaves the road
	a_lane_range: assert property (@(posedge clk) disable iff (!arst_n)
		{30'b0, st_q.lane} < NL)
		else $error("lane index out of range");

	// a pass always sets the lock
	a_pass_locks: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (res_q.mode == MODE_LEFT || res_q.mode == MODE_RIGHT)
		|-> res_q.change_locked)
		else $error("pass without lock");

	// a frame end clears the per-frame flags
	a_flags_clear: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && item_s1.frame_end
		|=> !st_q.ahead && !st_q.left_busy && !st_q.right_busy)
		else $error("frame flags not cleared");

	// only a frame-end item can raise a result
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(adv_s1 && item_s1.frame_end) && (!out_valid_q || m_tready) |=> !m_tvalid)
		else $error("result without frame end");

endmodule

### hw/rtl/lcd_decide.sv
`timescale 1ns / 1ps

// Flag update and frame-end decision for one item; purely combinational.
module lcd_decide
	import lcd_pkg::*;
#(
	parameter int LANE_COUNT = 3
) (
	input  item_t   item,
	input  state_t  st,
	input  cfg_t    cfg,
	output state_t  st_nxt,
	output result_t res
);

	localparam int NL = (LANE_COUNT > 4) ? 4 : ((LANE_COUNT < 1) ? 1 : LANE_COUNT);
	localparam logic [2:0] NL3 = 3'(NL);

	logic [17:0] os_ext, ego_ext, gap_ext;
	logic        near, od_inner, has_right;
	logic        hit_own, hit_left, hit_right;
	logic        ahead, lbusy, rbusy, lock_eff, can_left, can_right, pass;
	logic [1:0]  od_lane, lane, lane_nxt;
	mode_t       mode;
	logic [12:0] sum13;
	logic [11:0] speed_nxt;

	assign lane    = st.lane;
	assign os_ext  = {1'b0, item.other_s};
	assign ego_ext = {1'b0, item.ego_s};
	assign gap_ext = {8'b0, cfg.safety_gap};

	// strict window around ego, no wrap
	assign near      = (os_ext + gap_ext > ego_ext) && (os_ext < ego_ext + gap_ext);
	// strictly inside lane k: upper bits equal k, lower bits nonzero
	assign od_lane   = item.other_d[7:6];
	assign od_inner  = |item.other_d[5:0];
	assign has_right = ({1'b0, lane} + 3'd1) < NL3;

	assign hit_own   = item.other_valid && od_inner && (od_lane == lane)
		&& (item.other_s > item.ego_s) && (item.other_s < item.horizon_s);
	assign hit_left  = item.other_valid && (lane != 2'd0) && od_inner
		&& (od_lane == lane - 2'd1) && near;
	assign hit_right = item.other_valid && has_right && od_inner
		&& (od_lane == lane + 2'd1) && near;

	assign ahead = st.ahead | hit_own;
	assign lbusy = st.left_busy | hit_left;
	assign rbusy = st.right_busy | hit_right;

	// lock expiry is only looked at when something is ahead
	assign lock_eff  = st.locked && !(ahead && (st.fcount > cfg.lock_frames));
	assign can_left  = (lane != 2'd0) && !lbusy;
	assign can_right = has_right && !rbusy;

	always_comb begin
		if (!ahead) begin
			mode = MODE_KEEP;
		end else if (can_left && !lock_eff) begin
			mode = MODE_LEFT;
		end else if (can_right && !lock_eff) begin
			mode = MODE_RIGHT;
		end else begin
			mode = MODE_TRACK;
		end
	end

	assign pass  = (mode == MODE_LEFT) || (mode == MODE_RIGHT);
	assign sum13 = {1'b0, st.speed} + {5'b0, cfg.speed_step};

	always_comb begin
		speed_nxt = st.speed;
		if (mode == MODE_TRACK) begin
			speed_nxt = (st.speed > {4'b0, cfg.speed_step})
				? st.speed - {4'b0, cfg.speed_step} : '0;
		end else if (st.speed < cfg.max_speed) begin
			speed_nxt = sum13[12] ? '1 : sum13[11:0];
		end
	end

	always_comb begin
		case (mode)
			MODE_LEFT:  lane_nxt = lane - 2'd1;
			MODE_RIGHT: lane_nxt = lane + 2'd1;
			default:    lane_nxt = lane;
		endcase
	end

	always_comb begin
		st_nxt = st;
		if (item.frame_end) begin
			st_nxt.lane       = lane_nxt;
			st_nxt.speed      = speed_nxt;
			st_nxt.locked     = pass | lock_eff;
			if (pass) begin
				st_nxt.fcount = 8'd1;
			end else if (st.fcount != '1) begin
				st_nxt.fcount = st.fcount + 8'd1;
			end
			st_nxt.ahead      = 1'b0;
			st_nxt.left_busy  = 1'b0;
			st_nxt.right_busy = 1'b0;
		end else begin
			st_nxt.ahead      = ahead;
			st_nxt.left_busy  = lbusy;
			st_nxt.right_busy = rbusy;
		end
	end

	assign res.lane          = lane_nxt;
	assign res.mode          = mode;
	assign res.ref_speed     = speed_nxt;
	assign res.target_d      = {lane_nxt, 6'd32};
	assign res.change_locked = pass | lock_eff;

endmodule
